### hw/rtl/lpn2sc_pkg.sv
// Shared types and constants for the length-prefixed NAL to start-code converter.
// No dependencies.
`timescale 1ns / 1ps

package lpn2sc_pkg;

	localparam logic [31:0] MAX_SAMPLE_BYTES = 32'd819200;

	localparam logic [7:0] HDR_SPS   = 8'h67;
	localparam logic [7:0] HDR_VPS   = 8'h40;
	localparam logic [7:0] HDR_SLICE = 8'h41;
	localparam logic [7:0] SC_TAIL   = 8'h01;

	localparam logic [2:0] WANT_SPS   = 3'd3;
	localparam logic [2:0] WANT_VPS   = 3'd4;
	localparam logic [2:0] WANT_SLICE = 3'd1;
	localparam logic [2:0] WANT_NONE  = 3'd0;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_HDR = 2'd1,
		ST_SHORT   = 2'd2,
		ST_BAD_LEN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_FIRST_LEN,
		PH_FIRST_HDR,
		PH_PAYLOAD,
		PH_LEN,
		PH_TAIL,
		PH_DROP
	} phase_t;

	// Results caused by one input transfer: optional start code, optional byte,
	// end-of-sample mark with status.
	typedef struct packed {
		logic       sc;
		logic       has_byte;
		logic [7:0] data;
		logic       last;
		status_t    status;
	} bundle_t;

	function automatic logic [2:0] nals_for_header(input logic [7:0] hdr);
		logic [2:0] w;
		case (hdr)
			HDR_SPS:   w = WANT_SPS;
			HDR_VPS:   w = WANT_VPS;
			HDR_SLICE: w = WANT_SLICE;
			default:   w = WANT_NONE;
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/lpn2sc_parser.sv
// Sample parser: length prefixes, first header decode, payload counting.
// Depends on lpn2sc_pkg.
`timescale 1ns / 1ps

module lpn2sc_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           sample_byte,
	input  logic                 sample_end,
	output logic                 push,
	output lpn2sc_pkg::bundle_t  bundle
);
	import lpn2sc_pkg::*;

	phase_t      phase_q, phase_w, phase_d;
	logic [1:0]  pos_q, pos_d;
	logic [31:0] acc_q, acc_d, acc_shift;
	logic [19:0] left_q, left_d, left_dec;
	logic [2:0]  idx_q, idx_d, idx_inc;
	logic [2:0]  want_q, want_d, want_hdr;
	status_t     err_q, err_w, err_d;
	logic        len_bad, hdr_ok;

	assign acc_shift = {acc_q[23:0], sample_byte};
	assign left_dec  = left_q - 20'd1;
	assign want_hdr  = nals_for_header(sample_byte);
	assign hdr_ok    = (want_hdr != WANT_NONE);
	assign len_bad   = (acc_shift == 32'd0) || (acc_shift > MAX_SAMPLE_BYTES);

	// next state
	always_comb begin
		phase_w = phase_q;
		err_w   = err_q;
		pos_d   = pos_q;
		acc_d   = acc_q;
		left_d  = left_q;
		idx_d   = idx_q;
		want_d  = want_q;
		idx_inc = idx_q + 3'd1;
		case (phase_q)
			PH_FIRST_LEN, PH_LEN: begin
				acc_d = acc_shift;
				pos_d = pos_q + 2'd1;
				if (pos_q == 2'd3) begin
					if (len_bad) begin
						err_w   = ST_BAD_LEN;
						phase_w = PH_DROP;
					end else begin
						left_d  = acc_shift[19:0];
						phase_w = (phase_q == PH_FIRST_LEN) ? PH_FIRST_HDR : PH_PAYLOAD;
					end
				end
			end
			PH_FIRST_HDR: begin
				want_d = want_hdr;
				if (!hdr_ok) begin
					err_w   = ST_BAD_HDR;
					phase_w = PH_DROP;
				end else begin
					left_d  = left_dec;
					idx_inc = 3'd1;
					idx_d   = 3'd0;
					phase_w = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
			end
			default: begin
			end
		endcase
		if (phase_w == PH_PAYLOAD && (phase_q == PH_PAYLOAD || phase_q == PH_FIRST_HDR)
				&& left_dec == 20'd0) begin
			idx_d = idx_inc;
			if (idx_inc >= want_d) begin
				phase_w = PH_TAIL;
			end else begin
				phase_w = PH_LEN;
				pos_d   = 2'd0;
				acc_d   = 32'd0;
			end
		end
		phase_d = phase_w;
		err_d   = err_w;
		if (sample_end) begin
			phase_d = PH_FIRST_LEN;
			err_d   = ST_OK;
			pos_d   = 2'd0;
			acc_d   = 32'd0;
			left_d  = 20'd0;
			idx_d   = 3'd0;
			want_d  = WANT_NONE;
		end
	end

	// outputs
	always_comb begin
		bundle.sc       = ((phase_q == PH_LEN) && (pos_q == 2'd3) && !len_bad)
			|| ((phase_q == PH_FIRST_HDR) && hdr_ok);
		bundle.has_byte = ((phase_q == PH_FIRST_HDR) && hdr_ok) || (phase_q == PH_PAYLOAD);
		bundle.data     = sample_byte;
		bundle.last     = sample_end;
		case (phase_w)
			PH_DROP: bundle.status = err_w;
			PH_TAIL: bundle.status = ST_OK;
			default: bundle.status = ST_SHORT;
		endcase
		push = take && (bundle.sc || bundle.has_byte || sample_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST_LEN;
			err_q   <= ST_OK;
			pos_q   <= 2'd0;
			acc_q   <= 32'd0;
			left_q  <= 20'd0;
			idx_q   <= 3'd0;
			want_q  <= WANT_NONE;
		end else if (take) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			pos_q   <= pos_d;
			acc_q   <= acc_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			want_q  <= want_d;
		end
	end

endmodule

### hw/rtl/lpn2sc_serialiser.sv
// Two-entry result queue and serialiser: one result per transfer.
// Depends on lpn2sc_pkg.
`timescale 1ns / 1ps

module lpn2sc_serialiser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lpn2sc_pkg::bundle_t  bundle,
	output logic                 full,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 last_of_sample,
	output logic [1:0]           status
);
	import lpn2sc_pkg::*;

	bundle_t    fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic [2:0] sub_q, last_sub;
	bundle_t    head;
	logic       xfer, pop;

	assign head         = fifo_q[rd_q];
	assign full         = (cnt_q == 2'd2);
	assign result_valid = (cnt_q != 2'd0);
	assign xfer         = result_valid && !result_stall;
	assign last_sub     = head.sc ? (head.has_byte ? 3'd4 : 3'd3) : 3'd0;
	assign pop          = xfer && (sub_q == last_sub);

	always_comb begin
		if (head.sc && sub_q < 3'd4)
			out_byte = (sub_q == 3'd3) ? SC_TAIL : 8'h00;
		else if (head.has_byte)
			out_byte = head.data;
		else
			out_byte = 8'h00;
		byte_valid     = head.sc || head.has_byte;
		last_of_sample = head.last && (sub_q == last_sub);
		status         = last_of_sample ? head.status : ST_OK;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
			sub_q <= 3'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop)
				sub_q <= 3'd0;
			else if (xfer)
				sub_q <= sub_q + 3'd1;
		end
	end

endmodule

### hw/rtl/length_prefixed_nal_to_start_code.sv
// Top level of the length-prefixed NAL to start-code converter.
// Depends on lpn2sc_pkg, lpn2sc_parser, lpn2sc_serialiser.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------------
//  sample   | sample_valid | sample_stall | sample_byte, sample_end
//  result   | result_valid | result_stall | out_byte, byte_valid, last_of_sample, status
//
// One byte per cycle while the result queue is not full; a byte that brings a start code
// gives four or five results, one per cycle from the two-entry result queue while
// result_stall is low. sample_stall is high only while that queue is full, and each
// transfer's results are registered in the queue before they appear on the output.
// Reset clears parser state and empties the queue.
`timescale 1ns / 1ps

module length_prefixed_nal_to_start_code (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	input  logic [7:0] sample_byte,
	input  logic       sample_end,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last_of_sample,
	output logic [1:0] status
);
	import lpn2sc_pkg::*;

	logic    take, push, full;
	bundle_t bundle;

	assign sample_stall = full;
	assign take         = sample_valid && !full;

	lpn2sc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.sample_byte (sample_byte),
		.sample_end  (sample_end),
		.push        (push),
		.bundle      (bundle)
	);

	lpn2sc_serialiser u_ser (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.bundle         (bundle),
		.full           (full),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.last_of_sample (last_of_sample),
		.status         (status)
	);

endmodule

### tb/sv/tb.sv
// Self-checking bench for length_prefixed_nal_to_start_code: byte streams in, start-code stream out.
// Uses lpn2sc_pkg for header, status and phase codes; predicts each transfer in a scoreboard class.
`timescale 1ns / 1ps

module tb;
	import lpn2sc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEM_TARGET    = 320;
	localparam int CALM_FROM      = 270;

	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       last;
		status_t    st;
	} out_rec_t;

	class nal_conv_scoreboard;
		out_rec_t   pending_out[$];
		out_rec_t   burst[$];
		int         errors;
		phase_t     stage;
		logic [2:0] pfx_cnt;
		logic [31:0] len_shift;
		logic [19:0] bytes_left;
		logic [2:0] nal_done;
		logic [2:0] nal_goal;
		status_t    drop_code;

		function new();
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			stage      = PH_FIRST_LEN;
			pfx_cnt    = '0;
			len_shift  = '0;
			bytes_left = '0;
			nal_done   = '0;
			nal_goal   = WANT_NONE;
			drop_code  = ST_OK;
		endfunction

		function void emit(logic [7:0] d);
			out_rec_t r;
			r.data  = d;
			r.valid = 1'b1;
			r.last  = 1'b0;
			r.st    = ST_OK;
			burst.push_back(r);
		endfunction

		function void emit_start_code();
			emit(8'h00);
			emit(8'h00);
			emit(8'h00);
			emit(SC_TAIL);
		endfunction

		function void close_nal();
			if (bytes_left != 0)
				return;
			nal_done = nal_done + 3'd1;
			if (nal_done >= nal_goal) begin
				stage = PH_TAIL;
			end else begin
				stage     = PH_LEN;
				pfx_cnt   = '0;
				len_shift = '0;
			end
		endfunction

		// works out the results of one accepted byte and queues them
		function void take_byte(logic [7:0] b, logic fin);
			out_rec_t r;
			status_t  st;
			burst.delete();
			case (stage)
				PH_FIRST_LEN, PH_LEN: begin
					len_shift = {len_shift[23:0], b};
					pfx_cnt   = pfx_cnt + 3'd1;
					if (pfx_cnt >= 3'd4) begin
						pfx_cnt = '0;
						if (len_shift == 0 || len_shift > MAX_SAMPLE_BYTES) begin
							drop_code = ST_BAD_LEN;
							stage     = PH_DROP;
						end else begin
							bytes_left = len_shift[19:0];
							if (stage == PH_FIRST_LEN) begin
								stage = PH_FIRST_HDR;
							end else begin
								emit_start_code();
								stage = PH_PAYLOAD;
							end
						end
					end
				end
				PH_FIRST_HDR: begin
					case (b)
						HDR_SPS:   nal_goal = WANT_SPS;
						HDR_VPS:   nal_goal = WANT_VPS;
						HDR_SLICE: nal_goal = WANT_SLICE;
						default:   nal_goal = WANT_NONE;
					endcase
					if (nal_goal == WANT_NONE) begin
						drop_code = ST_BAD_HDR;
						stage     = PH_DROP;
					end else begin
						emit_start_code();
						emit(b);
						nal_done   = '0;
						bytes_left = bytes_left - 20'd1;
						stage      = PH_PAYLOAD;
						close_nal();
					end
				end
				PH_PAYLOAD: begin
					emit(b);
					bytes_left = bytes_left - 20'd1;
					close_nal();
				end
				default: ;
			endcase
			if (fin) begin
				if (stage == PH_DROP)
					st = drop_code;
				else if (stage == PH_TAIL)
					st = ST_OK;
				else
					st = ST_SHORT;
				if (burst.size() == 0) begin
					r.data  = 8'h00;
					r.valid = 1'b0;
					r.last  = 1'b0;
					r.st    = ST_OK;
					burst.push_back(r);
				end
				burst[burst.size() - 1].last = 1'b1;
				burst[burst.size() - 1].st   = st;
				clear_state();
			end
			foreach (burst[i])
				pending_out.push_back(burst[i]);
		endfunction

		function void check_result(logic [7:0] d, logic v, logic l, logic [1:0] s);
			out_rec_t e;
			if (pending_out.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: byte %02h valid %0d last %0d status %0d",
						d, v, l, s);
				errors++;
				return;
			end
			e = pending_out.pop_front();
			if (d !== e.data || v !== e.valid || l !== e.last || s !== e.st) begin
				if (errors < 10)
					$display({"mismatch at %0t: expected byte %02h valid %0d last %0d status %s,",
						" got byte %02h valid %0d last %0d status %0d"},
						$realtime, e.data, e.valid, e.last, e.st.name(), d, v, l, s);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       sample_valid;
	logic       sample_stall;
	logic [7:0] sample_byte;
	logic       sample_end;
	logic       result_valid;
	logic       result_stall;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_of_sample;
	logic [1:0] status;

	nal_conv_scoreboard sb = new();
	int   sent;
	int   idle_cycles;
	logic [7:0] smp[$];

	length_prefixed_nal_to_start_code dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_byte    (sample_byte),
		.sample_end     (sample_end),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.last_of_sample (last_of_sample),
		.status         (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// transfers on both channels, prediction before checking, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				sb.take_byte(sample_byte, sample_end);
				sent++;
			end
			if (result_valid && !result_stall)
				sb.check_result(out_byte, byte_valid, last_of_sample, status);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("length_prefixed_nal_to_start_code verification failed");
				$finish;
			end
		end
	end

	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sent < CALM_FROM && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_stall <= 1'b0;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fin);
		if (sent < CALM_FROM && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_byte  <= b;
		sample_end   <= fin;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic send_sample();
		foreach (smp[i])
			push_byte(smp[i], i == smp.size() - 1);
	endtask

	task automatic put_len(input logic [31:0] n);
		smp.push_back(n[31:24]);
		smp.push_back(n[23:16]);
		smp.push_back(n[15:8]);
		smp.push_back(n[7:0]);
	endtask

	function automatic logic [31:0] bad_len();
		case ($urandom_range(0, 3))
			0:       return 32'd0;
			1:       return MAX_SAMPLE_BYTES + 32'd1;
			2:       return 32'hFFFF_FFFF;
			default: return $urandom() | 32'h0010_0000;
		endcase
	endfunction

	// mostly well-formed samples with random payloads, some broken or noise
	task automatic build_sample();
		logic [7:0] hdr;
		int n, len, cut, kind;
		smp.delete();
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 8)) smp.push_back(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 2))
			0:       begin hdr = HDR_SPS;   n = WANT_SPS;   end
			1:       begin hdr = HDR_VPS;   n = WANT_VPS;   end
			default: begin hdr = HDR_SLICE; n = WANT_SLICE; end
		endcase
		if (kind == 8)
			hdr = 8'($urandom_range(0, 255));
		cut = (kind == 7) ? $urandom_range(0, n - 1) : -1;
		for (int k = 0; k < n; k++) begin
			if (k == cut) begin
				put_len(bad_len());
				repeat ($urandom_range(0, 3)) smp.push_back(8'($urandom_range(0, 255)));
				return;
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
			put_len(len);
			for (int j = 0; j < len; j++)
				smp.push_back((k == 0 && j == 0) ? hdr : 8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 3)) smp.push_back(8'($urandom_range(0, 255)));
		if (kind == 6) begin
			len = $urandom_range(1, smp.size());
			while (smp.size() > len) void'(smp.pop_back());
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_byte  = 8'h00;
		sample_end   = 1'b0;
		sent         = 0;
		idle_cycles  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		smp = '{8'h00, 8'h00, 8'h00, 8'h02, HDR_SLICE, 8'hAA};
		send_sample();
		smp = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h55};
		send_sample();
		smp = '{8'h00, 8'h00, 8'h00, 8'h00};
		send_sample();
		smp = '{8'h00, 8'h0C, 8'h80, 8'h01};
		send_sample();
		smp = '{8'hFF};
		send_sample();
		smp = '{8'h00, 8'h0C, 8'h80, 8'h00, HDR_SPS};
		send_sample();

		while (sent < ITEM_TARGET) begin
			build_sample();
			send_sample();
		end

		sample_valid <= 1'b0;
		while (sb.pending_out.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (sb.errors == 0)
			$display("length_prefixed_nal_to_start_code verification clean");
		else
			$display("length_prefixed_nal_to_start_code verification failed");
		$finish;
	end

endmodule

### sim.f
hw/rtl/lpn2sc_pkg.sv
hw/rtl/lpn2sc_parser.sv
hw/rtl/lpn2sc_serialiser.sv
hw/rtl/length_prefixed_nal_to_start_code.sv
tb/sv/tb.sv
